/* rtl/core/bhj_pkg.sv */
package bhj_pkg;

  // Command codes carried in the command field of an input transfer.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PROBE  = 2'd2
  } command_t;

  // Status codes carried in the status field of a result transfer.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_MATCH = 2'd2,
    STAT_NONE  = 2'd3
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_EXEC,
    S_PROBE,
    S_FINISH
  } state_t;

  // Access request to the bucket fill store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic sweep;
  } fill_ctrl_t;

  // Access request to the slot store.
  typedef struct packed {
    logic rd;
    logic wr;
  } slot_ctrl_t;

endpackage

/* rtl/core/bhj_cmd_if.sv */
interface bhj_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] tuple_key;
  logic [31:0] tuple_value;

  modport source (output valid, output command, output tuple_key, output tuple_value,
                  input ready);
  modport sink (input valid, input command, input tuple_key, input tuple_value,
                output ready);
endinterface

/* rtl/core/bhj_res_if.sv */
interface bhj_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] right_key;
  logic [31:0] right_value;
  logic [31:0] left_key;
  logic [31:0] left_value;
  logic        last;

  modport source (output valid, output status, output right_key, output right_value,
                  output left_key, output left_value, output last, input ready);
  modport sink (input valid, input status, input right_key, input right_value,
                input left_key, input left_value, input last, output ready);
endinterface

/* rtl/core/bhj_bucket_mod.sv */
module bhj_bucket_mod #(
  parameter int BUCKET_COUNT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [31:0]                     value,
  output logic                            done,
  output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

  localparam int BW = $clog2(BUCKET_COUNT);

  if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_mask
    // A power-of-two count reduces to the low bits of the value.
    logic [BW-1:0] bucket_r;
    logic          done_r;

    always_ff @(posedge clk) begin
      if (rst) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        bucket_r <= value[BW-1:0];
      end
    end

    assign done   = done_r;
    assign bucket = bucket_r;
  end else begin : g_iter
    // Restoring reduction, four value bits per cycle over all 32 value bits.
    localparam int RW = BW + 1;

    logic [RW-1:0] rem;
    logic [RW-1:0] rem_next;
    logic [31:0]   shreg;
    logic [2:0]    cnt;
    logic          busy;
    logic          done_r;

    always_comb begin
      rem_next = rem;
      for (int k = 0; k < 4; k++) begin
        rem_next = {rem_next[RW-2:0], shreg[31-k]};
        if (rem_next >= RW'(BUCKET_COUNT)) begin
          rem_next = rem_next - RW'(BUCKET_COUNT);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        busy   <= 1'b0;
        done_r <= 1'b0;
        cnt    <= '0;
      end else begin
        done_r <= 1'b0;
        if (start) begin
          busy <= 1'b1;
          cnt  <= '0;
        end else if (busy) begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            busy   <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        shreg <= value;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[27:0], 4'd0};
        rem   <= rem_next;
      end
    end

    assign done   = done_r;
    assign bucket = rem[BW-1:0];
  end

endmodule

/* rtl/core/bhj_fill_store.sv */
module bhj_fill_store #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bhj_pkg::fill_ctrl_t      ctrl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        rd_data,
  output logic                     busy
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     cnt;

  // The clearing pass owns the write side of the port while it runs and writes zero one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (ctrl.sweep) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + AW'(1);
      if (cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[cnt] <= '0;
    end else if (ctrl.wr) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* rtl/core/bhj_slot_store.sv */
module bhj_slot_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  bhj_pkg::slot_ctrl_t      ctrl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [31:0]              wr_key,
  input  logic [31:0]              wr_value,
  output logic [31:0]              rd_key,
  output logic [31:0]              rd_value
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= {wr_key, wr_value};
    end
    if (ctrl.rd) begin
      {rd_key, rd_value} <= mem[addr];
    end
  end

endmodule

/* rtl/core/bucket_hash_join.sv */
// Insert, clear and unused codes pass through the hash unit, the execute state and the output
// register; a probe then walks the filled slots of its bucket and ends with a final result.
// When BUCKET_COUNT is not a power of two, the modulo unit reduces four value bits per cycle.
// Items are handled one at a time; a probe reads the filled slots of its bucket from the slot memory.
// Reset and clear start a clearing pass over the fill memory, with no input transfer taken
// until it ends.
module bucket_hash_join #(
  parameter int BUCKET_COUNT = 256,
  parameter int BUCKET_SLOTS = 16
) (
  input logic      clk,
  input logic      rst,
  bhj_cmd_if.sink  cmd,
  bhj_res_if.source res
);

  localparam int BW    = $clog2(BUCKET_COUNT);
  localparam int FW    = $clog2(BUCKET_SLOTS + 1);
  localparam int TOTAL = BUCKET_COUNT * BUCKET_SLOTS;
  localparam int SA    = $clog2(TOTAL);

  bhj_pkg::state_t state;
  bhj_pkg::state_t state_next;

  // Captured input transfer.
  logic [1:0]  cmd_q;
  logic [31:0] key_q;
  logic [31:0] val_q;
  logic [BW-1:0] bucket_q;

  // Probe walk state: next slot to read, read data pending, held-back match.
  logic [FW-1:0] idx;
  logic [FW-1:0] idx_next;
  logic          rvalid;
  logic          rvalid_next;
  logic          pend_valid;
  logic          pend_valid_next;
  logic          pend_take;
  logic [31:0]   pend_key;
  logic [31:0]   pend_value;

  // Hash unit.
  logic          hash_start;
  logic          hash_done;
  logic [BW-1:0] hash_bucket;

  // Fill store port.
  bhj_pkg::fill_ctrl_t fill_ctrl;
  logic [BW-1:0]       fill_addr;
  logic [FW-1:0]       fill_wdata;
  logic [FW-1:0]       fill_rd;
  logic                fill_busy;

  // Slot store port.
  bhj_pkg::slot_ctrl_t slot_ctrl;
  logic [SA-1:0]       slot_addr;
  logic [SA-1:0]       slot_base;
  logic [31:0]         slot_rkey;
  logic [31:0]         slot_rvalue;

  // Result loaded into the output register.
  logic                emit;
  logic                out_free;
  logic                hit;
  bhj_pkg::status_t    e_status;
  logic [31:0]         e_rk;
  logic [31:0]         e_rv;
  logic [31:0]         e_lk;
  logic [31:0]         e_lv;
  logic                e_last;

  bhj_bucket_mod #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .value  (cmd.tuple_value),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  bhj_fill_store #(
    .DEPTH  (BUCKET_COUNT),
    .DATA_W (FW)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fill_ctrl),
    .addr    (fill_addr),
    .wr_data (fill_wdata),
    .rd_data (fill_rd),
    .busy    (fill_busy)
  );

  bhj_slot_store #(
    .DEPTH (TOTAL)
  ) u_slot (
    .clk      (clk),
    .ctrl     (slot_ctrl),
    .addr     (slot_addr),
    .wr_key   (key_q),
    .wr_value (val_q),
    .rd_key   (slot_rkey),
    .rd_value (slot_rvalue)
  );

  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !res.valid || res.ready;
  assign slot_base = SA'(bucket_q) * SA'(BUCKET_SLOTS);
  assign hit       = rvalid && (slot_rvalue == val_q);
  assign cmd.ready = (state == bhj_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhj_pkg::S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    hash_start      = 1'b0;
    fill_ctrl       = '0;
    fill_addr       = bucket_q;
    fill_wdata      = fill_rd + FW'(1);
    slot_ctrl       = '0;
    slot_addr       = slot_base + SA'(idx);
    idx_next        = idx;
    rvalid_next     = rvalid;
    pend_valid_next = pend_valid;
    pend_take       = 1'b0;
    emit            = 1'b0;
    e_status        = bhj_pkg::STAT_DONE;
    e_rk            = '0;
    e_rv            = '0;
    e_lk            = '0;
    e_lv            = '0;
    e_last          = 1'b1;

    unique case (state)
      bhj_pkg::S_SWEEP: begin
        if (!fill_busy) begin
          state_next = bhj_pkg::S_IDLE;
        end
      end

      bhj_pkg::S_IDLE: begin
        if (cmd.valid) begin
          hash_start = 1'b1;
          state_next = bhj_pkg::S_HASH;
        end
      end

      bhj_pkg::S_HASH: begin
        // The fill count of the bucket is read as soon as the bucket is known.
        if (hash_done) begin
          fill_ctrl.rd = 1'b1;
          fill_addr    = hash_bucket;
          state_next   = bhj_pkg::S_EXEC;
        end
      end

      bhj_pkg::S_EXEC: begin
        unique case (cmd_q)
          bhj_pkg::CMD_CLEAR: begin
            if (out_free) begin
              emit            = 1'b1;
              fill_ctrl.sweep = 1'b1;
              state_next      = bhj_pkg::S_SWEEP;
            end
          end
          bhj_pkg::CMD_INSERT: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = bhj_pkg::S_IDLE;
              if (fill_rd < FW'(BUCKET_SLOTS)) begin
                fill_ctrl.wr = 1'b1;
                slot_ctrl.wr = 1'b1;
                slot_addr    = slot_base + SA'(fill_rd);
              end else begin
                e_status = bhj_pkg::STAT_DROP;
              end
            end
          end
          bhj_pkg::CMD_PROBE: begin
            idx_next        = '0;
            rvalid_next     = 1'b0;
            pend_valid_next = 1'b0;
            state_next      = bhj_pkg::S_PROBE;
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = bhj_pkg::S_IDLE;
            end
          end
        endcase
      end

      bhj_pkg::S_PROBE: begin
        // A match is held back until the next one shows up, so that only the final
        // match carries last. The walk stalls when the held match cannot be sent.
        if (!(hit && pend_valid && !out_free)) begin
          if (hit) begin
            pend_take       = 1'b1;
            pend_valid_next = 1'b1;
            if (pend_valid) begin
              emit     = 1'b1;
              e_status = bhj_pkg::STAT_MATCH;
              e_rk     = pend_key;
              e_rv     = pend_value;
              e_lk     = key_q;
              e_lv     = val_q;
              e_last   = 1'b0;
            end
          end
          if (idx < fill_rd) begin
            slot_ctrl.rd = 1'b1;
            idx_next     = idx + FW'(1);
            rvalid_next  = 1'b1;
          end else begin
            rvalid_next = 1'b0;
            if (!rvalid) begin
              state_next = bhj_pkg::S_FINISH;
            end
          end
        end
      end

      bhj_pkg::S_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          e_lk       = key_q;
          e_lv       = val_q;
          state_next = bhj_pkg::S_IDLE;
          if (pend_valid) begin
            e_status = bhj_pkg::STAT_MATCH;
            e_rk     = pend_key;
            e_rv     = pend_value;
          end else begin
            e_status = bhj_pkg::STAT_NONE;
          end
        end
      end

      default: begin
        state_next = bhj_pkg::S_IDLE;
      end
    endcase
  end

  // Walk control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rvalid     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      idx        <= idx_next;
      rvalid     <= rvalid_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload capture: the input transfer, the bucket and the held match.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= cmd.command;
      key_q <= cmd.tuple_key;
      val_q <= cmd.tuple_value;
    end
    if (hash_done) begin
      bucket_q <= hash_bucket;
    end
    if (pend_take) begin
      pend_key   <= slot_rkey;
      pend_value <= slot_rvalue;
    end
  end

  // Output register; it parts the result side from the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status      <= e_status;
      res.right_key   <= e_rk;
      res.right_value <= e_rv;
      res.left_key    <= e_lk;
      res.left_value  <= e_lv;
      res.last        <= e_last;
    end
  end

  // A new result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result register overwritten");

  // An insert writes a slot only while the bucket has room.
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    slot_ctrl.wr |-> (fill_rd < FW'(BUCKET_SLOTS)) && (state == bhj_pkg::S_EXEC))
    else $error("slot written into a full bucket");

  // The probe walk never runs past the fill count of its bucket.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bhj_pkg::S_PROBE) |-> (idx <= fill_rd))
    else $error("probe index beyond fill count");

  // No input transfer is taken while the clearing pass still runs.
  a_sweep_lock: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> !cmd.ready)
    else $error("input taken during clearing pass");

endmodule
